[hw/rtl/bal_pkg.sv]
package bal_pkg;

  localparam int CAP_DEFAULT = 8;

  localparam int OP_W   = 3;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int FPOS_W = 3;
  localparam int CNT_W  = 4;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_LEFT,
    SEL_RIGHT
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t sel;
  } cell_ctrl_t;

endpackage

[hw/rtl/bal_req_if.sv]
interface bal_req_if import bal_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, operation, position, item_value, input ready);
  modport sink (input valid, operation, position, item_value, output ready);
endinterface

[hw/rtl/bal_rsp_if.sv]
interface bal_rsp_if import bal_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] read_value;
  logic [FPOS_W-1:0]       found_position;
  logic [CNT_W-1:0]        entry_count;

  modport source (output valid, status, read_value, found_position, entry_count,
                  input ready);
  modport sink (input valid, status, read_value, found_position, entry_count,
                output ready);
endinterface

[hw/rtl/bounded_array_list_top.sv]
// Latency: a result beat is valid in the cycle after its request beat is taken.
// Throughput: one request per cycle while result beats are taken; each request
// is done in a single pass through the row of entry cells.
// Reset: synchronous, active high; clears the entry count and the result valid.
// Entry cells are not cleared; only entries below the count are ever read.
module bounded_array_list_top import bal_pkg::*; #(
  parameter int CAPACITY = CAP_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  bal_req_if.sink  req,
  bal_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [CW-1:0]     count;
  logic [XW-1:0]     cnt_x;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_next_x;
  logic [XW-1:0]     hit_pos;
  logic              full;
  logic              accept;
  logic              hit;
  logic [STAT_W-1:0] status_next;
  logic [VAL_W-1:0]  read_next;
  logic [FPOS_W-1:0] fpos_next;

  logic [VAL_W-1:0]    cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  cell_ctrl_t          cell_ctrl [CAPACITY];

  assign cnt_x     = XW'(count);
  assign pos_x     = XW'(req.position);
  assign full      = (cnt_x >= XW'(CAPACITY));
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl[i].sel = SEL_HOLD;
      if (accept) begin
        case (req.operation)
          OP_APPEND: begin
            if (!full && XW'(i) == cnt_x) cell_ctrl[i].sel = SEL_LOAD;
          end
          OP_REMOVE: begin
            if (pos_x < cnt_x && XW'(i) >= pos_x && XW'(i + 1) < cnt_x)
              cell_ctrl[i].sel = SEL_RIGHT;
          end
          OP_INSERT: begin
            if (pos_x <= cnt_x && !full) begin
              if (XW'(i) == pos_x) cell_ctrl[i].sel = SEL_LOAD;
              else if (XW'(i) > pos_x && XW'(i) <= cnt_x) cell_ctrl[i].sel = SEL_LEFT;
            end
          end
          default: cell_ctrl[i].sel = SEL_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_value;
    logic [VAL_W-1:0] right_value;

    if (g == 0) begin : g_left_end
      assign left_value = '0;
    end else begin : g_left
      assign left_value = cell_value[g-1];
    end

    if (g == CAPACITY - 1) begin : g_right_end
      assign right_value = '0;
    end else begin : g_right
      assign right_value = cell_value[g+1];
    end

    bal_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[g]),
      .load_value (req.item_value),
      .left_value (left_value),
      .right_value(right_value),
      .key        (req.item_value),
      .value      (cell_value[g]),
      .hit        (cell_hit[g])
    );
  end

  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_hit[i] && XW'(i) < cnt_x) begin
        hit     = 1'b1;
        hit_pos = XW'(i);
      end
    end
  end

  always_comb begin
    status_next = ST_OK;
    read_next   = '0;
    fpos_next   = '0;
    cnt_next_x  = cnt_x;
    case (req.operation)
      OP_APPEND: begin
        if (full) status_next = ST_FULL;
        else cnt_next_x = cnt_x + XW'(1);
      end
      OP_REMOVE: begin
        if (pos_x >= cnt_x) status_next = ST_RANGE;
        else cnt_next_x = cnt_x - XW'(1);
      end
      OP_GET: begin
        if (pos_x >= cnt_x) status_next = ST_RANGE;
        else read_next = cell_value[pos_x[IW-1:0]];
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) status_next = ST_RANGE;
        else if (full) status_next = ST_FULL;
        else cnt_next_x = cnt_x + XW'(1);
      end
      OP_SEARCH: begin
        if (!hit) status_next = ST_MISSING;
        else fpos_next = hit_pos[FPOS_W-1:0];
      end
      default: status_next = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else if (accept) begin
      count     <= cnt_next_x[CW-1:0];
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status         <= status_next;
      rsp.read_value     <= read_next;
      rsp.found_position <= fpos_next;
      rsp.entry_count    <= cnt_next_x[CNT_W-1:0];
    end
  end

endmodule

[hw/rtl/bal_cell.sv]
module bal_cell import bal_pkg::*; (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] load_value,
  input  logic [VAL_W-1:0] left_value,
  input  logic [VAL_W-1:0] right_value,
  input  logic [VAL_W-1:0] key,
  output logic [VAL_W-1:0] value,
  output logic             hit
);

  always_ff @(posedge clk) begin
    case (ctrl.sel)
      SEL_LOAD:  value <= load_value;
      SEL_LEFT:  value <= left_value;
      SEL_RIGHT: value <= right_value;
      default:   value <= value;
    endcase
  end

  assign hit = (value == key);

endmodule

[hw/rtl/bal_checker.sv]
module bal_checker import bal_pkg::*; #(
  parameter int CAPACITY = CAP_DEFAULT
) (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [STAT_W-1:0] status,
  input logic [CNT_W-1:0]  entry_count
);

  // a taken request yields a result beat in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("result beat missing after request");

  // hold off requests while a result beat is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken over a stalled result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CAPACITY > 15) || (entry_count <= CNT_W'(CAPACITY)))
    else $error("entry count above capacity");

  a_full_at_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> (CAPACITY > 15) || (entry_count == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_count))
    else $error("stalled result beat changed");

endmodule

bind bounded_array_list_top bal_checker #(.CAPACITY(CAPACITY)) u_bal_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .entry_count(rsp.entry_count)
);

[tb/tb_bounded_array_list_top.sv]
`timescale 1ns / 1ps

module tb_bounded_array_list_top;
  import bal_pkg::*;

  localparam int CAPACITY    = CAP_DEFAULT;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_SEARCH + 1'b1;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } list_request_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [FPOS_W-1:0]       found_position;
    logic [CNT_W-1:0]        entry_count;
  } list_result_t;

  logic clk;
  logic rst;

  bal_req_if req_bus ();
  bal_rsp_if rsp_bus ();

  bounded_array_list_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus.sink),
    .rsp(rsp_bus.source)
  );

  list_request_t           request_queue[$];
  list_result_t            expected_results[$];
  logic signed [VAL_W-1:0] list_words[CAPACITY];
  int                      list_len;
  logic signed [VAL_W-1:0] value_pool[8];
  int                      request_total;
  int                      issued;
  int                      failures;
  int                      cycle_count;
  int                      hold_left;
  bit                      hold_done;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic list_result_t apply_list_request(list_request_t r);
    list_result_t res;
    int           i;
    bit           hit;
    res = '0;
    hit = 1'b0;
    case (r.operation)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_len] = r.item_value;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (r.position >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = r.position; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      OP_GET: begin
        if (r.position >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = list_words[r.position];
        end
      end
      OP_INSERT: begin
        if (r.position > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i > r.position; i--) list_words[i] = list_words[i - 1];
          list_words[r.position] = r.item_value;
          list_len++;
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < list_len && !hit; i++) begin
          if (list_words[i] == r.item_value) begin
            hit = 1'b1;
            res.found_position = i[FPOS_W-1:0];
          end
        end
        if (!hit) res.status = ST_MISSING;
      end
      default: ;
    endcase
    res.entry_count = list_len[CNT_W-1:0];
    return res;
  endfunction

  task automatic queue_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] val);
    list_request_t r;
    r.operation  = op;
    r.position   = pos;
    r.item_value = val;
    request_queue.push_back(r);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(99) < 60) return value_pool[3'($urandom_range(7))];
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_operation(bit filling);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
    if (filling) begin
      if (roll < 38) return OP_APPEND;
      if (roll < 63) return OP_INSERT;
      if (roll < 73) return OP_REMOVE;
      if (roll < 88) return OP_GET;
      return OP_SEARCH;
    end
    if (roll < 13) return OP_APPEND;
    if (roll < 23) return OP_INSERT;
    if (roll < 63) return OP_REMOVE;
    if (roll < 83) return OP_GET;
    return OP_SEARCH;
  endfunction

  function automatic int sender_idle_pct();
    if (issued < request_total / 3) return 7;
    if (issued < 2 * request_total / 3) return 74;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (issued < request_total / 3) return 74;
    if (issued < 2 * request_total / 3) return 7;
    return 0;
  endfunction

  // driver: advance only when the current beat is taken or none is offered
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_bus.ready) begin
      if (request_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
        {req_bus.operation, req_bus.position, req_bus.item_value} <=
          request_queue.pop_front();
        req_bus.valid <= 1'b1;
        issued <= issued + 1;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req_bus.valid && req_bus.ready) begin
      expected_results.push_back(apply_list_request(
        {req_bus.operation, req_bus.position, req_bus.item_value}));
    end
  end

  // receiver: hold off once for a long stretch while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && issued >= 2 * request_total / 3 + 50) begin
      rsp_bus.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no request pending");
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
          failures++;
        end
        if (rsp_bus.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, rsp_bus.read_value);
          failures++;
        end
        if (rsp_bus.found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 want.found_position, rsp_bus.found_position);
          failures++;
        end
        if (rsp_bus.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_bus.entry_count);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int  n;
    int  run_left;
    bit  filling;
    logic [POS_W-1:0] pos;
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.operation = OP_APPEND;
    req_bus.position = '0;
    req_bus.item_value = '0;
    rsp_bus.ready = 1'b0;
    list_len = 0;
    issued = 0;
    failures = 0;
    cycle_count = 0;
    hold_left = 0;
    hold_done = 1'b0;
    value_pool = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1, 32'sd1,
                   32'sd42, -32'sd7, 32'sh5555_aaaa};

    queue_request(OP_REMOVE, 4'd0, 32'sd0);
    queue_request(OP_GET, 4'd0, 32'sd0);
    queue_request(OP_SEARCH, 4'd0, 32'sd5);
    queue_request(OP_INSERT, 4'd1, 32'sd9);
    queue_request(OP_APPEND, 4'd15, 32'sh8000_0000);
    queue_request(OP_APPEND, 4'd0, 32'sh7fff_ffff);
    queue_request(OP_INSERT, 4'd0, -32'sd1);
    queue_request(OP_INSERT, 4'd3, 32'sd0);
    queue_request(OP_GET, 4'd3, 32'sd0);
    queue_request(OP_SEARCH, 4'd15, 32'sh7fff_ffff);
    queue_request(OP_SEARCH, 4'd0, 32'sd12345);
    queue_request(OP_FIRST_UNUSED, 4'd15, -32'sd1);
    queue_request(OP_LAST_UNUSED, 4'd15, 32'sh7fff_ffff);
    for (n = 0; n < 4; n++) queue_request(OP_APPEND, 4'd0, 32'sh5555_aaaa ^ n);
    queue_request(OP_APPEND, 4'd0, 32'sd77);
    queue_request(OP_INSERT, 4'd8, 32'sd77);
    queue_request(OP_INSERT, 4'd9, 32'sd77);
    queue_request(OP_INSERT, 4'd15, 32'sd77);
    queue_request(OP_GET, 4'd7, 32'sd0);
    queue_request(OP_GET, 4'd8, 32'sd0);
    queue_request(OP_REMOVE, 4'd7, 32'sd0);
    queue_request(OP_REMOVE, 4'd0, 32'sd0);
    queue_request(OP_REMOVE, 4'd15, 32'sd0);

    filling = 1'b1;
    run_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (run_left == 0) begin
        filling = ~filling;
        run_left = $urandom_range(40, 10);
      end
      run_left--;
      if ($urandom_range(99) < 80) pos = POS_W'($urandom_range(CAPACITY));
      else pos = POS_W'($urandom_range(15));
      queue_request(pick_operation(filling), pos, pick_value());
    end
    request_total = request_queue.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (request_queue.size() > 0 || req_bus.valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/bal_pkg.sv
hw/rtl/bal_req_if.sv
hw/rtl/bal_rsp_if.sv
hw/rtl/bal_cell.sv
hw/rtl/bounded_array_list_top.sv
hw/rtl/bal_checker.sv
tb/tb_bounded_array_list_top.sv
